// ===== rtl/core/retry_queue_with_backoff_core_macros.svh =====
// Assertion helpers for the retry queue core.
`ifndef RETRY_QUEUE_WITH_BACKOFF_CORE_MACROS_SVH
`define RETRY_QUEUE_WITH_BACKOFF_CORE_MACROS_SVH

// Implication checked every clock outside reset.
`define RQB_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define RQB_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/rqb_pkg.sv =====
package rqb_pkg;

   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned CFG_W = 16;
   localparam int unsigned CFG_IDX_W = 2;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_PUSH_RETRY = 3'd1,
      OP_POP = 3'd2,
      OP_SCAN = 3'd3,
      OP_CLEANUP = 3'd4,
      OP_TICK = 3'd5,
      OP_RSV6 = 3'd6,
      OP_RSV7 = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      RK_STATUS = 2'd0,
      RK_POPPED = 2'd1,
      RK_RETRY = 2'd2,
      RK_DROPPED = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CFG_BASE = 2'd0,
      CFG_CAP = 2'd1,
      CFG_LIMIT = 2'd2,
      CFG_AGE = 2'd3
   } cfg_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_SEND
   } state_type;

   typedef struct packed {
      logic [7:0] kind;
      logic [15:0] handle;
      logic [31:0] destination;
      logic [31:0] timestamp;
      logic [31:0] next_retry;
      logic [3:0] attempts;
      logic retry_enabled;
   } entry_type;

   // Per-cell control.
   typedef struct packed {
      logic load;
      logic rotate;
      logic update_head;
   } cell_ctrl_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== rtl/core/retry_queue_with_backoff_core.sv =====
// Retry queue with exponential backoff, built as a chain of entry cells.
// Input: req_valid/req_ready carry one command (push, retry push, pop,
// retry scan, cleanup, tick). Output: rsp_valid/rsp_ready carry result
// transfers; rsp_last marks the final result of a command.
// Config: csr_write_enable, csr_index, csr_write_data; write only while idle.
// Order: push, tick, reserved opcodes and error cases load their status at
// acceptance; it can transfer at the next edge. A pop loads its entry from
// the walk state. Scan and cleanup visit the n live entries one per cycle
// unless an event waits for the result register: the head is judged, then
// either dropped (the live part shifts down) or sent to the tail of the live
// part, so order is kept, and each event is registered as it is judged.
// The send state then loads the final status. The next command is accepted
// at the edge that takes the final result. One command is in work at a time.
// Reset clears the occupancy count, seconds counter, registers to defaults
// and the controller; entry contents stay undefined until pushed.
// A stalled receiver holds the result register; the walk pauses before the
// next event until the transfer completes, so nothing is lost.
`include "retry_queue_with_backoff_core_macros.svh"
module retry_queue_with_backoff_core
   import rqb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
)
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [OPCODE_W-1:0] req_opcode,
   input logic [7:0] req_message_kind,
   input logic [15:0] req_message_handle,
   input logic [31:0] req_destination,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_kind,
   output logic [15:0] rsp_out_handle,
   output logic [31:0] rsp_out_destination,
   output logic [31:0] rsp_out_timestamp,
   output logic [3:0] rsp_out_attempts,
   output logic [31:0] rsp_out_next_retry,
   output logic [15:0] rsp_out_interval,
   output logic [4:0] rsp_out_count,
   output logic rsp_last,
   input logic csr_write_enable,
   input logic [CFG_IDX_W-1:0] csr_index,
   input logic [CFG_W-1:0] csr_write_data
);

   localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers.
   logic [7:0] base_ff;
   logic [15:0] cap_ff;
   logic [3:0] limit_ff;
   logic [15:0] age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 8'd2;
         cap_ff <= 16'd30;
         limit_ff <= 4'd3;
         age_ff <= 16'd60;
      end else if (csr_write_enable) begin
         unique case (cfg_index_type'(csr_index))
            CFG_BASE: base_ff <= csr_write_data[7:0];
            CFG_CAP: cap_ff <= csr_write_data;
            CFG_LIMIT: limit_ff <= csr_write_data[3:0];
            CFG_AGE: age_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Control state.
   state_type state_ff, state_in;
   opcode_type op_ff;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] step_ff, step_in;   // original entries still to visit
   logic [4:0] count_ff, count_in;
   logic [31:0] now_ff;

   // Result register.
   logic rsp_valid_ff;
   logic [1:0] r_rk_ff, r_st_ff;
   entry_type r_ent_ff;
   logic [15:0] r_iv_ff;
   logic [4:0] r_cnt_ff;
   logic r_last_ff;

   // Chain of cells. Cell 0 is the head (oldest live entry).
   entry_type cell_q [QUEUE_DEPTH];
   entry_type load_data;
   entry_type tail_in;

   // Head evaluation for the current walk step.
   entry_type head;
   entry_type head_new;
   logic due, drop_scan, retry_now, drop_clean;
   logic [22:0] shifted;
   logic [15:0] iv;
   logic [31:0] age;

   assign head = cell_q[0];

   always_comb begin
      shifted = {15'd0, base_ff} << head.attempts;
      iv = (shifted > {7'd0, cap_ff}) ? cap_ff : shifted[15:0];
      due = head.retry_enabled && (now_ff >= head.next_retry);
      drop_scan = due && (head.attempts >= limit_ff);
      retry_now = due && !drop_scan;
      age = (now_ff >= head.timestamp) ? now_ff - head.timestamp : 32'd0;
      drop_clean = (age > {16'd0, age_ff}) || (head.attempts > limit_ff);
      head_new = head;
      head_new.attempts = head.attempts + 4'd1;
      head_new.next_retry = sat_add32(now_ff, {16'd0, iv});
   end

   // A pop is a one-step walk that always drops and reports the head.
   logic walk_drop, walk_event;
   always_comb begin
      walk_drop = 1'b0;
      walk_event = 1'b0;
      unique case (op_ff)
         OP_POP: begin
            walk_drop = 1'b1;
            walk_event = 1'b1;
         end
         OP_SCAN: begin
            walk_drop = drop_scan;
            walk_event = due;
         end
         OP_CLEANUP: begin
            walk_drop = drop_clean;
            walk_event = drop_clean;
         end
         default: ;
      endcase
   end

   // A step with an event waits until the result register is free.
   logic rsp_free, walking, step_go, ev_load, fin_load;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign walking = (state_ff == S_WALK) && (step_ff != '0);
   assign step_go = walking && (!walk_event || rsp_free);
   assign ev_load = step_go && walk_event;
   assign fin_load = (state_ff == S_SEND) && rsp_free;

   opcode_type req_op;
   logic accept, is_walk_op, imm_load, do_push;
   assign req_op = opcode_type'(req_opcode);
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign accept = req_valid && req_ready;
   assign is_walk_op = (req_op == OP_SCAN) || (req_op == OP_CLEANUP) ||
      (req_op == OP_POP && occ_ff != '0);
   assign imm_load = accept && !is_walk_op;
   assign do_push = accept && (req_op == OP_PUSH || req_op == OP_PUSH_RETRY) &&
      req_message_handle != 16'd0 && occ_ff < CNT_W'(QUEUE_DEPTH);

   logic [IDX_W-1:0] occ_idx;
   assign occ_idx = occ_ff[IDX_W-1:0];

   always_comb begin
      load_data.kind = req_message_kind;
      load_data.handle = req_message_handle;
      load_data.timestamp = now_ff;
      load_data.attempts = 4'd0;
      if (req_op == OP_PUSH_RETRY) begin
         load_data.destination = req_destination;
         load_data.next_retry = sat_add32(now_ff, {24'd0, base_ff});
         load_data.retry_enabled = 1'b1;
      end else begin
         load_data.destination = 32'd0;
         load_data.next_retry = 32'd0;
         load_data.retry_enabled = 1'b0;
      end
   end

   // A kept head, with its retry update, goes to the top of the live part.
   assign tail_in = (op_ff == OP_SCAN && retry_now) ? head_new : head;

   logic [CNT_W-1:0] tail_pos;
   assign tail_pos = occ_ff - 1'b1;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         entry_type nb;
         cell_ctrl_type c;
         always_comb begin
            c.load = do_push;
            c.rotate = step_go && (CNT_W'(g) < tail_pos);
            c.update_head = step_go && !walk_drop && (CNT_W'(g) == tail_pos);
         end
         if (g == QUEUE_DEPTH - 1) begin : g_top
            assign nb = cell_q[g];
         end else begin : g_mid
            assign nb = cell_q[g+1];
         end
         rqb_cell u_cell (
            .clock (clock),
            .ctrl (c),
            .load_data (load_data),
            .load_here (occ_idx == IDX_W'(g)),
            .neighbor (nb),
            .head_update (tail_in),
            .entry (cell_q[g])
         );
      end
   endgenerate

   // Controller next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept && is_walk_op) state_in = S_WALK;
         S_WALK: begin
            if (op_ff == OP_POP) begin
               if (step_go) state_in = S_IDLE;
            end else if (step_ff == '0) begin
               state_in = S_SEND;
            end
         end
         S_SEND: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Controller datapath.
   always_comb begin
      occ_in = occ_ff;
      step_in = step_ff;
      count_in = count_ff;
      if (accept) begin
         count_in = '0;
         step_in = (req_op == OP_POP) ? CNT_W'(1) : occ_ff;
         if (do_push) occ_in = occ_ff + 1'b1;
      end else if (step_go) begin
         step_in = step_ff - 1'b1;
         if (walk_drop) occ_in = occ_ff - 1'b1;
         if ((op_ff == OP_SCAN && retry_now) || (op_ff == OP_CLEANUP && drop_clean))
            count_in = count_ff + 5'd1;
      end
   end

   logic seconds_max;
   assign seconds_max = (now_ff == 32'hFFFF_FFFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff <= '0;
         step_ff <= '0;
         count_ff <= '0;
         now_ff <= '0;
         op_ff <= OP_RSV7;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         step_ff <= step_in;
         count_ff <= count_in;
         if (accept) begin
            op_ff <= req_op;
            if (req_op == OP_TICK && !seconds_max) now_ff <= now_ff + 32'd1;
         end
      end
   end

   // Status of a command answered at acceptance.
   status_type imm_st;
   always_comb begin
      imm_st = ST_OK;
      unique case (req_op)
         OP_PUSH, OP_PUSH_RETRY: begin
            if (req_message_handle == 16'd0) imm_st = ST_NULL;
            else if (occ_ff >= CNT_W'(QUEUE_DEPTH)) imm_st = ST_FULL;
         end
         OP_POP: imm_st = ST_EMPTY;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (imm_load || ev_load || fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_load) begin
         r_st_ff <= ST_OK;
         r_cnt_ff <= 5'd0;
         if (op_ff == OP_POP) begin
            r_rk_ff <= RK_POPPED;
            r_ent_ff <= head;
            r_iv_ff <= 16'd0;
            r_last_ff <= 1'b1;
         end else if (op_ff == OP_SCAN && retry_now) begin
            r_rk_ff <= RK_RETRY;
            r_ent_ff <= head_new;
            r_iv_ff <= iv;
            r_last_ff <= 1'b0;
         end else begin
            r_rk_ff <= RK_DROPPED;
            r_ent_ff <= head;
            r_iv_ff <= 16'd0;
            r_last_ff <= 1'b0;
         end
      end else if (imm_load || fin_load) begin
         r_rk_ff <= RK_STATUS;
         r_st_ff <= imm_load ? imm_st : ST_OK;
         r_ent_ff <= '0;
         r_iv_ff <= 16'd0;
         r_cnt_ff <= fin_load ? count_ff : 5'd0;
         r_last_ff <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = r_rk_ff;
   assign rsp_status = r_st_ff;
   assign rsp_out_kind = r_ent_ff.kind;
   assign rsp_out_handle = r_ent_ff.handle;
   assign rsp_out_destination = r_ent_ff.destination;
   assign rsp_out_timestamp = r_ent_ff.timestamp;
   assign rsp_out_attempts = r_ent_ff.attempts;
   assign rsp_out_next_retry = r_ent_ff.next_retry;
   assign rsp_out_interval = r_iv_ff;
   assign rsp_out_count = r_cnt_ff;
   assign rsp_last = r_last_ff;

   `RQB_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(QUEUE_DEPTH),
      "occupancy over depth")
   `RQB_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req_ready,
      "accept while busy")
   `RQB_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "result dropped while stalled")

endmodule

// ===== rtl/core/rqb_cell.sv =====
module rqb_cell
   import rqb_pkg::*;
(
   input logic clock,
   input cell_ctrl_type ctrl,
   input entry_type load_data,
   input logic load_here,
   input entry_type neighbor,
   input entry_type head_update,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // Rotate: each cell takes its upper neighbor; the cell at the top of the live part takes the head update.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.rotate) begin
         entry_in = neighbor;
      end else if (ctrl.load && load_here) begin
         entry_in = load_data;
      end else if (ctrl.update_head) begin
         entry_in = head_update;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== bench/retry_queue_with_backoff_core_tb.sv =====
`timescale 1ns / 1ps
// Checks the retry queue core against a behavioral model of the queue that
// lives in this bench. A short table of commands walks the corner cases
// (empty, null handle, full queue, due and dropped entries, reserved opcodes),
// and a cleanup after it drops aged-out entries. Random traffic then runs under
// three register settings and three idling patterns. Every response transfer
// is compared in order against the expected response queue.
module retry_queue_with_backoff_core_tb;
   import rqb_pkg::*;

   localparam int DEPTH = 16;
   localparam int DIR_N = 21;
   localparam int RAND_PER_PHASE = 125;

   // one expected or observed response transfer
   typedef struct packed {
      result_kind_type rkind;
      status_type st;
      logic [7:0] kind;
      logic [15:0] handle;
      logic [31:0] destination;
      logic [31:0] timestamp;
      logic [3:0] attempts;
      logic [31:0] next_retry;
      logic [15:0] interval;
      logic [4:0] count;
      logic last;
   } rsp_t;

   // directed command row; has_exp marks a typed-in single status response
   typedef struct {
      opcode_type op;
      logic [7:0] kind;
      logic [15:0] handle;
      logic [31:0] destination;
      int reps;
      bit has_exp;
      status_type exp_st;
   } cmd_row_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [2:0] req_opcode;
   logic [7:0] req_message_kind;
   logic [15:0] req_message_handle;
   logic [31:0] req_destination;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_result_kind;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_kind;
   logic [15:0] rsp_out_handle;
   logic [31:0] rsp_out_destination;
   logic [31:0] rsp_out_timestamp;
   logic [3:0] rsp_out_attempts;
   logic [31:0] rsp_out_next_retry;
   logic [15:0] rsp_out_interval;
   logic [4:0] rsp_out_count;
   logic rsp_last;
   logic csr_write_enable;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_write_data;

   // model state: queue contents, fill level, seconds counter, registers
   entry_type q_slot [DEPTH];
   int unsigned q_fill;
   logic [31:0] q_now;
   logic [7:0] cfg_base;
   logic [15:0] cfg_cap;
   logic [3:0] cfg_limit;
   logic [15:0] cfg_age;

   rsp_t pending_rsp [$];
   int mismatches;
   int send_idle_pct;
   int recv_idle_pct;
   cmd_row_t dir_tab [DIR_N];

   retry_queue_with_backoff_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20ms;
      $display("retry_queue_with_backoff_core test failed");
      $finish;
   end

   function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic rsp_t status_rsp(input status_type st, input logic [4:0] cnt);
      rsp_t r;
      r = '0;
      r.rkind = RK_STATUS;
      r.st = st;
      r.count = cnt;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_t entry_rsp(input result_kind_type rk, input entry_type e,
                                      input logic [15:0] iv);
      rsp_t r;
      r = '0;
      r.rkind = rk;
      r.st = ST_OK;
      r.kind = e.kind;
      r.handle = e.handle;
      r.destination = e.destination;
      r.timestamp = e.timestamp;
      r.attempts = e.attempts;
      r.next_retry = e.next_retry;
      r.interval = iv;
      return r;
   endfunction

   // Apply one accepted command to the model and queue its responses.
   task automatic apply_command(input opcode_type op, input logic [7:0] kind,
                                input logic [15:0] handle, input logic [31:0] dest);
      int unsigned w;
      int unsigned cnt;
      logic due;
      logic [31:0] iv;
      logic [31:0] age;
      entry_type e;
      w = 0;
      cnt = 0;
      case (op)
         OP_PUSH, OP_PUSH_RETRY: begin
            if (handle == 16'd0) begin
               pending_rsp.push_back(status_rsp(ST_NULL, 5'd0));
            end else if (q_fill >= DEPTH) begin
               pending_rsp.push_back(status_rsp(ST_FULL, 5'd0));
            end else begin
               e = '0;
               e.kind = kind;
               e.handle = handle;
               e.timestamp = q_now;
               if (op == OP_PUSH_RETRY) begin
                  e.destination = dest;
                  e.next_retry = sat_sum(q_now, {24'd0, cfg_base});
                  e.retry_enabled = 1'b1;
               end
               q_slot[q_fill] = e;
               q_fill++;
               pending_rsp.push_back(status_rsp(ST_OK, 5'd0));
            end
         end
         OP_POP: begin
            if (q_fill == 0) begin
               pending_rsp.push_back(status_rsp(ST_EMPTY, 5'd0));
            end else begin
               e = q_slot[0];
               pending_rsp.push_back(entry_rsp(RK_POPPED, e, 16'd0));
               pending_rsp[$].last = 1'b1;
               for (int r = 1; r < q_fill; r++) q_slot[r-1] = q_slot[r];
               q_fill--;
            end
         end
         OP_SCAN: begin
            for (int r = 0; r < q_fill; r++) begin
               e = q_slot[r];
               due = e.retry_enabled && (q_now >= e.next_retry);
               if (due && e.attempts >= cfg_limit) begin
                  // out of attempts: dropped, slot not kept
                  pending_rsp.push_back(entry_rsp(RK_DROPPED, e, 16'd0));
               end else begin
                  if (due) begin
                     iv = {24'd0, cfg_base} << e.attempts;
                     if (iv > {16'd0, cfg_cap}) iv = {16'd0, cfg_cap};
                     e.attempts = e.attempts + 4'd1;
                     e.next_retry = sat_sum(q_now, iv);
                     pending_rsp.push_back(entry_rsp(RK_RETRY, e, iv[15:0]));
                     cnt++;
                  end
                  q_slot[w] = e;
                  w++;
               end
            end
            q_fill = w;
            pending_rsp.push_back(status_rsp(ST_OK, cnt[4:0]));
         end
         OP_CLEANUP: begin
            for (int r = 0; r < q_fill; r++) begin
               e = q_slot[r];
               age = (q_now >= e.timestamp) ? q_now - e.timestamp : 32'd0;
               if (age > {16'd0, cfg_age} || e.attempts > cfg_limit) begin
                  pending_rsp.push_back(entry_rsp(RK_DROPPED, e, 16'd0));
                  cnt++;
               end else begin
                  q_slot[w] = e;
                  w++;
               end
            end
            q_fill = w;
            pending_rsp.push_back(status_rsp(ST_OK, cnt[4:0]));
         end
         OP_TICK: begin
            if (q_now != 32'hFFFF_FFFF) q_now++;
            pending_rsp.push_back(status_rsp(ST_OK, 5'd0));
         end
         default: begin
            pending_rsp.push_back(status_rsp(ST_OK, 5'd0));
         end
      endcase
   endtask

   // Drive one command from a falling edge and hold it until the transfer.
   // When has_exp is set the typed-in status replaces the modeled response.
   task automatic send_command(input opcode_type op, input logic [7:0] kind,
                               input logic [15:0] handle, input logic [31:0] dest,
                               input bit has_exp, input status_type exp_st);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_message_kind = kind;
      req_message_handle = handle;
      req_destination = dest;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_command(op, kind, handle, dest);
      if (has_exp) begin
         void'(pending_rsp.pop_back());
         pending_rsp.push_back(status_rsp(exp_st, 5'd0));
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Let every expected transfer come back, then give the chain time to settle.
   task automatic drain_responses();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_csr(input cfg_index_type idx, input logic [CFG_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      case (idx)
         CFG_BASE: cfg_base = data[7:0];
         CFG_CAP: cfg_cap = data;
         CFG_LIMIT: cfg_limit = data[3:0];
         default: cfg_age = data;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic load_settings(input logic [7:0] base, input logic [15:0] cap,
                                input logic [3:0] lim, input logic [15:0] age);
      drain_responses();
      write_csr(CFG_BASE, {8'd0, base});
      write_csr(CFG_CAP, cap);
      write_csr(CFG_LIMIT, {12'd0, lim});
      write_csr(CFG_AGE, age);
   endtask

   // Random traffic, weighted toward pushes so the queue fills and retries fire.
   task automatic random_phase(input int n);
      int pick;
      opcode_type op;
      logic [15:0] h;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 22) op = OP_PUSH;
         else if (pick < 50) op = OP_PUSH_RETRY;
         else if (pick < 60) op = OP_POP;
         else if (pick < 74) op = OP_SCAN;
         else if (pick < 82) op = OP_CLEANUP;
         else if (pick < 96) op = OP_TICK;
         else op = opcode_type'($urandom_range(7, 6));
         h = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
         send_command(op, 8'($urandom), h, $urandom, 1'b0, ST_OK);
         // one mid-phase hold-off until the queue of responses runs dry
         if (i == n / 3) drain_responses();
      end
   endtask

   // receiver backpressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_t got;
      rsp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.rkind = result_kind_type'(rsp_result_kind);
         got.st = status_type'(rsp_status);
         got.kind = rsp_out_kind;
         got.handle = rsp_out_handle;
         got.destination = rsp_out_destination;
         got.timestamp = rsp_out_timestamp;
         got.attempts = rsp_out_attempts;
         got.next_retry = rsp_out_next_retry;
         got.interval = rsp_out_interval;
         got.count = rsp_out_count;
         got.last = rsp_last;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t\n  exp %p\n  got %p", $realtime, want, got);
            end
         end
      end
   end

   initial begin
      // corner cases under reset register values
      dir_tab = '{
         '{OP_POP, 8'h00, 16'h0000, 32'h0, 1, 1'b1, ST_EMPTY},
         '{OP_SCAN, 8'h00, 16'h0000, 32'h0, 1, 1'b0, ST_OK},
         '{OP_CLEANUP, 8'h00, 16'h0000, 32'h0, 1, 1'b0, ST_OK},
         '{OP_PUSH, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 1, 1'b1, ST_NULL},
         '{OP_PUSH_RETRY, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1, 1'b1, ST_NULL},
         '{OP_PUSH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, ST_OK},
         '{OP_PUSH_RETRY, 8'h00, 16'h0001, 32'hFFFF_FFFF, 1, 1'b1, ST_OK},
         '{OP_PUSH_RETRY, 8'h5A, 16'hFFFF, 32'h0000_0000, 1, 1'b1, ST_OK},
         '{OP_PUSH_RETRY, 8'hA5, 16'h1234, 32'h8000_0001, 13, 1'b1, ST_OK},
         '{OP_PUSH_RETRY, 8'h11, 16'h4321, 32'h1, 1, 1'b1, ST_FULL},
         '{OP_PUSH, 8'h11, 16'h0000, 32'h1, 1, 1'b1, ST_NULL},
         '{OP_TICK, 8'h00, 16'h0000, 32'h0, 2, 1'b1, ST_OK},
         '{OP_SCAN, 8'h00, 16'h0000, 32'h0, 1, 1'b0, ST_OK},
         '{OP_TICK, 8'h00, 16'h0000, 32'h0, 4, 1'b1, ST_OK},
         '{OP_SCAN, 8'h00, 16'h0000, 32'h0, 1, 1'b0, ST_OK},
         '{OP_TICK, 8'h00, 16'h0000, 32'h0, 40, 1'b1, ST_OK},
         '{OP_SCAN, 8'h00, 16'h0000, 32'h0, 2, 1'b0, ST_OK},
         '{OP_RSV6, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, ST_OK},
         '{OP_RSV7, 8'h00, 16'h0000, 32'h0, 1, 1'b1, ST_OK},
         '{OP_POP, 8'h00, 16'h0000, 32'h0, 2, 1'b0, ST_OK},
         '{OP_TICK, 8'h00, 16'h0000, 32'h0, 30, 1'b1, ST_OK}
      };
      mismatches = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_PUSH;
      req_message_kind = 8'd0;
      req_message_handle = 16'd0;
      req_destination = 32'd0;
      csr_write_enable = 1'b0;
      csr_index = CFG_BASE;
      csr_write_data = '0;
      q_fill = 0;
      q_now = 32'd0;
      cfg_base = 8'd2;
      cfg_cap = 16'd30;
      cfg_limit = 4'd3;
      cfg_age = 16'd60;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_N; i++) begin
         for (int n = 0; n < dir_tab[i].reps; n++)
            send_command(dir_tab[i].op, dir_tab[i].kind, dir_tab[i].handle,
                         dir_tab[i].destination, dir_tab[i].has_exp, dir_tab[i].exp_st);
      end
      // ages now past the default limit: cleanup clears the survivors
      send_command(OP_CLEANUP, 8'h00, 16'h0000, 32'h0, 1'b0, ST_OK);

      // low extremes, sender idles less than receiver
      send_idle_pct = 34;
      recv_idle_pct = 65;
      load_settings(8'd1, 16'd1, 4'd0, 16'd0);
      random_phase(RAND_PER_PHASE);

      // high extremes, roles swapped
      send_idle_pct = 65;
      recv_idle_pct = 34;
      load_settings(8'd255, 16'hFFFF, 4'd15, 16'hFFFF);
      random_phase(RAND_PER_PHASE);

      // middle values, no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(8'd3, 16'd40, 4'd4, 16'd25);
      random_phase(RAND_PER_PHASE);

      drain_responses();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("retry_queue_with_backoff_core test passed");
      end else begin
         $display("retry_queue_with_backoff_core test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rqb_pkg.sv
rtl/core/rqb_cell.sv
rtl/core/retry_queue_with_backoff_core.sv
bench/retry_queue_with_backoff_core_tb.sv
